// ===== sv/square_submatrix_counter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Square sub-grid counter: assertion macros
// Clocked on clk and disabled in reset; each use is a single assertion line.
// ----------------------------------------------------------------------------
`ifndef SQUARE_SUBMATRIX_COUNTER_UNIT_MACROS_SVH
`define SQUARE_SUBMATRIX_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication.
`define SSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssc: same-cycle check failed");

// Next-cycle implication.
`define SSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssc: next-cycle check failed");

`endif

// ===== sv/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// Square sub-grid counter package
// Field widths, queue item type and back-end state encoding.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int SIDE_W     = 7;
  localparam int COUNT_W    = 13;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;
  localparam int MIN_SIDE   = 2;

  typedef struct packed {
    logic              last;
    logic [SIDE_W-1:0] side;
  } ssc_item_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_EMIT,
    ST_SUB
  } ssc_state_t;

endpackage

// ===== sv/ssc_front.sv =====
// ----------------------------------------------------------------------------
// Square sub-grid counter front end
// Accepts cells, tracks row and column, computes the square side per cell.
// ----------------------------------------------------------------------------
module ssc_front #(
  parameter int MAX_N = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [ssc_pkg::SIDE_W-1:0] grid_n,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic                      cell_val,
  input  logic                      q_full,
  output logic                      q_push,
  output ssc_pkg::ssc_item_t        q_data
);
  import ssc_pkg::*;

  localparam int COL_W = $clog2(MAX_N);

  logic [SIDE_W-1:0] row_mem [MAX_N];
  logic [COL_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic [SIDE_W-1:0] left;
  logic [SIDE_W-1:0] diag;
  logic [SIDE_W-1:0] up_q;
  logic [SIDE_W-1:0] up;
  logic [SIDE_W-1:0] lft;
  logic [SIDE_W-1:0] dg;
  logic [SIDE_W-1:0] m;
  logic [SIDE_W-1:0] side;
  logic              last_col;
  logic              last_row;
  logic              fire;

  always_comb begin
    last_col = (SIDE_W'(col) == grid_n - SIDE_W'(1));
    last_row = (SIDE_W'(row) == grid_n - SIDE_W'(1));
    col_next = last_col ? '0 : col + COL_W'(1);
    up  = (row == '0) ? '0 : up_q;
    lft = (col == '0) ? '0 : left;
    dg  = (col == '0) ? '0 : diag;
    m   = (up < lft) ? up : lft;
    m   = (m < dg) ? m : dg;
    if (!cell_val) begin
      side = '0;
    end else if (row == '0 || col == '0) begin
      side = SIDE_W'(1);
    end else begin
      side = m + SIDE_W'(1);
    end
    if (side > grid_n) begin
      side = grid_n;
    end
  end

  assign s_tready    = !q_full;
  assign fire        = s_tvalid && !q_full;
  assign q_push      = fire;
  assign q_data.side = side;
  assign q_data.last = last_col && last_row;

  // Row buffer: write this column, prefetch the next column's upper side.
  always_ff @(posedge clk) begin
    if (fire) begin
      row_mem[col] <= side;
      up_q         <= row_mem[col_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row  <= '0;
      col  <= '0;
      left <= '0;
      diag <= '0;
    end else if (fire) begin
      diag <= up;
      left <= side;
      col  <= col_next;
      if (last_col) begin
        row <= last_row ? '0 : row + COL_W'(1);
      end
    end
  end

endmodule

// ===== sv/ssc_fifo.sv =====
// ----------------------------------------------------------------------------
// Square sub-grid counter queue
// Short queue of classified cells between front and back end.
// ----------------------------------------------------------------------------
module ssc_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               flush,
  input  logic               push,
  input  ssc_pkg::ssc_item_t push_data,
  output logic               full,
  input  logic               pop,
  output ssc_pkg::ssc_item_t pop_data,
  output logic               not_empty
);
  import ssc_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  ssc_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign full      = (fill == (PTR_W + 1)'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== sv/ssc_back.sv =====
// ----------------------------------------------------------------------------
// Square sub-grid counter back end
// Builds the side histogram and walks it into per-size square counts.
// ----------------------------------------------------------------------------
`include "square_submatrix_counter_unit_macros.svh"

module ssc_back #(
  parameter int MAX_N = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            restart,
  input  logic                            q_valid,
  input  ssc_pkg::ssc_item_t              q_data,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ssc_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tuser,
  output logic                            m_tlast
);
  import ssc_pkg::*;

  localparam int IDX_W = $clog2(MAX_N);

  logic [COUNT_W-1:0] hist [MAX_N];
  logic [MAX_N-1:0]   hist_vld;
  logic [COUNT_W-1:0] hist_rd;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [COUNT_W-1:0] wr_data;

  logic               upd_vld;
  logic [IDX_W-1:0]   upd_idx;
  logic               fw_vld;
  logic [IDX_W-1:0]   fw_idx;
  logic [COUNT_W-1:0] fw_data;
  logic [COUNT_W-1:0] upd_base;

  ssc_state_t         state;
  ssc_state_t         state_next;
  logic [SIDE_W-1:0]  k;
  logic [IDX_W-1:0]   k_idx;
  logic [COUNT_W-1:0] total;
  logic [SIDE_W-1:0]  max_side;
  logic [COUNT_W-1:0] sub_base;

  logic               pop_big;
  logic [IDX_W-1:0]   pop_idx;
  logic               slot_free;
  logic               emit_load;
  logic               emit_none;
  logic               emit_final;
  logic               clear_grid;

  logic [SIDE_W-1:0]  out_size;
  logic [COUNT_W-1:0] out_count;
  logic               out_found;
  logic               out_last;

  assign pop_idx   = IDX_W'(q_data.side - SIDE_W'(1));
  assign k_idx     = IDX_W'(k - SIDE_W'(1));
  assign slot_free = !m_tvalid || m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (q_valid && q_data.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = (max_side < SIDE_W'(MIN_SIDE) || k == max_side) ? ST_RUN : ST_SUB;
        end
      end
      ST_SUB: begin
        state_next = ST_EMIT;
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop      = (state == ST_RUN) && q_valid;
    pop_big    = q_pop && (q_data.side >= SIDE_W'(MIN_SIDE));
    emit_load  = (state == ST_EMIT) && slot_free;
    emit_none  = max_side < SIDE_W'(MIN_SIDE);
    emit_final = emit_none || (k == max_side);
    clear_grid = emit_load && emit_final;
    rd_en      = pop_big || (emit_load && !emit_none);
    rd_addr    = (state == ST_EMIT) ? k_idx : pop_idx;
  end

  // Read-modify-write with forwarding of the previous write.
  always_comb begin
    if (fw_vld && fw_idx == upd_idx) begin
      upd_base = fw_data;
    end else if (hist_vld[upd_idx]) begin
      upd_base = hist_rd;
    end else begin
      upd_base = '0;
    end
    wr_en    = upd_vld;
    wr_addr  = upd_idx;
    wr_data  = upd_base + COUNT_W'(1);
    sub_base = hist_vld[k_idx] ? hist_rd : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      hist_rd <= hist[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state    <= ST_RUN;
      upd_vld  <= 1'b0;
      fw_vld   <= 1'b0;
      hist_vld <= '0;
      total    <= '0;
      max_side <= '0;
      k        <= SIDE_W'(MIN_SIDE);
    end else begin
      state   <= state_next;
      upd_vld <= pop_big;
      fw_vld  <= upd_vld;
      if (clear_grid) begin
        hist_vld <= '0;
        total    <= '0;
        max_side <= '0;
      end else begin
        if (wr_en) begin
          hist_vld[wr_addr] <= 1'b1;
        end
        if (pop_big) begin
          total <= total + COUNT_W'(1);
          if (q_data.side > max_side) begin
            max_side <= q_data.side;
          end
        end else if (state == ST_SUB) begin
          total <= total - sub_base;
        end
      end
      if (state == ST_DRAIN) begin
        k <= SIDE_W'(MIN_SIDE);
      end else if (state == ST_SUB) begin
        k <= k + SIDE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_big) begin
      upd_idx <= pop_idx;
    end
    fw_idx  <= upd_idx;
    fw_data <= wr_data;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      m_tvalid <= 1'b0;
    end else if (emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_size  <= emit_none ? '0 : k;
      out_count <= emit_none ? '0 : total;
      out_found <= !emit_none;
      out_last  <= emit_final;
    end
  end

  assign m_tdata = {(OUT_DATA_W - COUNT_W - SIDE_W)'(0), out_count, out_size};
  assign m_tuser = out_found;
  assign m_tlast = out_last;

  `SSC_ASSERT_IMP(a_emit_count_nonzero, emit_load && !emit_none, total != '0)
  `SSC_ASSERT_IMP(a_sub_in_range, state == ST_SUB, k >= SIDE_W'(MIN_SIDE) && k < max_side)
  `SSC_ASSERT_NXT(a_drain_settles, state == ST_DRAIN, !upd_vld)
  `SSC_ASSERT_IMP(a_no_write_in_walk, state == ST_EMIT || state == ST_SUB, !wr_en)

endmodule

// ===== sv/square_submatrix_counter_unit.sv =====
// ----------------------------------------------------------------------------
// Square sub-grid counter
// Counts all-ones squares of every side 2..n in a streamed n-by-n bit grid.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one grid cell per word, row-major, cell value in
//   s_tdata[0]. The front end takes one word per cycle while the queue to the
//   back end has room, so cells stream at one per cycle.
//   Output channel m_*: after the final cell of a grid, one word per side with
//   a nonzero count, in ascending side order, m_tlast on the largest side. A
//   grid with no square of side two or more gives a single word with
//   m_tuser (found) low and m_tlast high.
//   Result timing: the first result word is loaded into the output register
//   from the EMIT state, which follows the DRAIN state entered when the final
//   cell leaves the queue; each further word takes a SUB and an EMIT state of
//   the side histogram walk (one memory read and one subtract per side).
//   While results are walked the back end holds the queue, the front end keeps
//   taking cells of the next grid until the queue fills.
//   A stalled receiver holds the output register and pauses the walk only.
//   cfg_wr_en writes grid_size and restarts the grid; write only while idle.
//   Reset sets grid_size to 64 and clears position, queue and histogram.
// ----------------------------------------------------------------------------
module square_submatrix_counter_unit #(
  parameter int MAX_N = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ssc_pkg::SIDE_W-1:0]     cfg_wr_data,  // grid_size
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ssc_pkg::IN_DATA_W-1:0]  s_tdata,      // [0] cell_req, rest zero
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ssc_pkg::OUT_DATA_W-1:0] m_tdata,      // [6:0] square_size,
                                                       // [19:7] square_count, pad
  output logic                           m_tuser,      // [0] found
  output logic                           m_tlast
);
  import ssc_pkg::*;

  logic [SIDE_W-1:0] grid_size;
  logic [SIDE_W-1:0] grid_n;
  logic              q_full;
  logic              q_push;
  ssc_item_t         q_in;
  logic              q_pop;
  ssc_item_t         q_out;
  logic              q_valid;

  // Hold the configured size; any write restarts the grid.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= SIDE_W'(64);
    end else if (cfg_wr_en) begin
      grid_size <= cfg_wr_data;
    end
  end

  // Clamp the size into the supported range.
  always_comb begin
    grid_n = grid_size;
    if (grid_n < SIDE_W'(MIN_SIDE)) begin
      grid_n = SIDE_W'(MIN_SIDE);
    end
    if (grid_n > SIDE_W'(MAX_N)) begin
      grid_n = SIDE_W'(MAX_N);
    end
  end

  ssc_front #(
    .MAX_N (MAX_N)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (cfg_wr_en),
    .grid_n   (grid_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cell_val (s_tdata[0]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  ssc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .flush     (cfg_wr_en),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_valid)
  );

  ssc_back #(
    .MAX_N (MAX_N)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .restart  (cfg_wr_en),
    .q_valid  (q_valid),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
